[hw/rtl/knp_pkg.sv]
// ----------------------------------------------------------------------------
// knp_pkg
// Shared types, codes and the character classifier of the kanji numeral
// parser.
// ----------------------------------------------------------------------------
package knp_pkg;

   localparam int CodePointWidth = 21;
   localparam int ValueWidth     = 30;
   localparam int GroupWidth     = 14;
   localparam int DigitWidth     = 4;

   // Character classes.
   localparam logic [2:0] CLS_UNKNOWN = 3'd0;
   localparam logic [2:0] CLS_DIGIT   = 3'd1;
   localparam logic [2:0] CLS_MUL     = 3'd2;
   localparam logic [2:0] CLS_MAN     = 3'd3;
   localparam logic [2:0] CLS_OKU     = 3'd4;

   // Multiplier selects; each is also the bit index in the seen mask.
   localparam logic [1:0] MUL_TEN      = 2'd0;
   localparam logic [1:0] MUL_HUNDRED  = 2'd1;
   localparam logic [1:0] MUL_THOUSAND = 2'd2;

   localparam logic [CodePointWidth-1:0] CP_TEN      = 21'h062FE;
   localparam logic [CodePointWidth-1:0] CP_HUNDRED  = 21'h0767E;
   localparam logic [CodePointWidth-1:0] CP_THOUSAND = 21'h05343;
   localparam logic [CodePointWidth-1:0] CP_MAN      = 21'h04E07;
   localparam logic [CodePointWidth-1:0] CP_OKU      = 21'h05104;

   typedef logic [CodePointWidth-1:0] cp_array_type [10];

   localparam cp_array_type DIGIT_CP = '{
      21'h096F6, 21'h058F1, 21'h05F10, 21'h053C2, 21'h056DB,
      21'h04E94, 21'h0516D, 21'h04E03, 21'h0516B, 21'h04E5D
   };

   // One classified character as it travels from the front to the back.
   typedef struct packed {
      logic [2:0]            cls;
      logic [DigitWidth-1:0] digit;
      logic [1:0]            mul_sel;
      logic                  last;
   } entry_type;

   function automatic entry_type classify(input logic [CodePointWidth-1:0] cp,
                                          input logic last);
      entry_type e;
      e.cls     = CLS_UNKNOWN;
      e.digit   = '0;
      e.mul_sel = MUL_TEN;
      e.last    = last;
      for (int i = 0; i < 10; i++) begin
         if (cp == DIGIT_CP[i]) begin
            e.cls   = CLS_DIGIT;
            e.digit = DigitWidth'(i);
         end
      end
      if (cp == CP_TEN) begin
         e.cls     = CLS_MUL;
         e.mul_sel = MUL_TEN;
      end
      if (cp == CP_HUNDRED) begin
         e.cls     = CLS_MUL;
         e.mul_sel = MUL_HUNDRED;
      end
      if (cp == CP_THOUSAND) begin
         e.cls     = CLS_MUL;
         e.mul_sel = MUL_THOUSAND;
      end
      if (cp == CP_MAN) begin
         e.cls = CLS_MAN;
      end
      if (cp == CP_OKU) begin
         e.cls = CLS_OKU;
      end
      return e;
   endfunction

endpackage

[hw/rtl/knp_front.sv]
// ----------------------------------------------------------------------------
// knp_front
// Accepts input words and sorts each code point into a character class.
// ----------------------------------------------------------------------------
module knp_front (
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [knp_pkg::CodePointWidth-1:0] req_code_point,
   input  logic                               req_last,
   output logic                               push,
   output knp_pkg::entry_type                 push_entry,
   input  logic                               queue_full
);

   assign req_ready  = !queue_full;
   assign push       = req_valid && !queue_full;
   assign push_entry = knp_pkg::classify(req_code_point, req_last);

endmodule

[hw/rtl/knp_queue.sv]
// ----------------------------------------------------------------------------
// knp_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module knp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  knp_pkg::entry_type push_entry,
   output logic               full,
   output logic               pop_valid,
   output knp_pkg::entry_type pop_entry,
   input  logic               pop
);

   knp_pkg::entry_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count above depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue popped while empty");

endmodule

[hw/rtl/knp_back.sv]
// ----------------------------------------------------------------------------
// knp_back
// Carries out each classified character on the parser state and registers
// the result word.
// ----------------------------------------------------------------------------
module knp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   input  knp_pkg::entry_type             pop_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [knp_pkg::ValueWidth-1:0] rsp_value,
   output logic                           rsp_error
);

   localparam int VW = knp_pkg::ValueWidth;
   localparam int GW = knp_pkg::GroupWidth;
   localparam int DW = knp_pkg::DigitWidth;

   logic [VW-1:0] total_ff, total_in;
   logic [GW-1:0] group_ff, group_in;
   logic [DW-1:0] pending_ff, pending_in;
   logic          seen_oku_ff, seen_oku_in;
   logic          seen_man_ff, seen_man_in;
   logic [2:0]    seen_mul_ff, seen_mul_in;
   logic          failed_ff, failed_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_error_ff, rsp_error_in;

   logic [DW-1:0] mult_digit;
   logic [2:0]    mul_bit;
   logic [9:0]    weight;
   logic [GW-1:0] term;
   logic [GW-1:0] grp;
   logic [26:0]   man_add;
   logic [VW-1:0] oku_add;
   logic [VW-1:0] value_next;

   // A last character needs the output register free; others never stall.
   assign pop = pop_valid && (!pop_entry.last || !rsp_valid_ff || rsp_ready);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

   always_comb begin
      mult_digit = (pending_ff == '0) ? DW'(1) : pending_ff;
      mul_bit    = 3'(1) << pop_entry.mul_sel;
      case (pop_entry.mul_sel)
         knp_pkg::MUL_TEN:      weight = 10'd10;
         knp_pkg::MUL_HUNDRED:  weight = 10'd100;
         knp_pkg::MUL_THOUSAND: weight = 10'd1000;
         default:               weight = 10'd0;
      endcase
      term    = GW'(mult_digit) * GW'(weight);
      grp     = group_ff + GW'(pending_ff);
      man_add = 27'(grp) * 27'd10000;
      oku_add = VW'(pending_ff) * VW'(100000000);

      total_in    = total_ff;
      group_in    = group_ff;
      pending_in  = pending_ff;
      seen_oku_in = seen_oku_ff;
      seen_man_in = seen_man_ff;
      seen_mul_in = seen_mul_ff;
      failed_in   = failed_ff;

      if (!failed_ff) begin
         case (pop_entry.cls)
            knp_pkg::CLS_DIGIT: begin
               pending_in = pop_entry.digit;
            end
            knp_pkg::CLS_MUL: begin
               if ((seen_mul_ff & mul_bit) != '0) begin
                  failed_in = 1'b1;
               end else begin
                  group_in    = group_ff + term;
                  seen_mul_in = seen_mul_ff | mul_bit;
                  pending_in  = '0;
               end
            end
            knp_pkg::CLS_MAN: begin
               if (seen_man_ff || grp == '0) begin
                  failed_in = 1'b1;
               end else begin
                  total_in    = total_ff + VW'(man_add);
                  seen_man_in = 1'b1;
                  group_in    = '0;
                  pending_in  = '0;
                  seen_mul_in = '0;
               end
            end
            knp_pkg::CLS_OKU: begin
               if (seen_oku_ff || seen_man_ff || group_ff != '0 || pending_ff == '0) begin
                  failed_in = 1'b1;
               end else begin
                  total_in    = total_ff + oku_add;
                  seen_oku_in = 1'b1;
                  pending_in  = '0;
                  seen_mul_in = '0;
               end
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
      end

      value_next = total_in + VW'(group_in) + VW'(pending_in);

      rsp_value_in = failed_in ? '0 : value_next;
      rsp_error_in = failed_in;

      if (pop && pop_entry.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         group_ff     <= '0;
         pending_ff   <= '0;
         seen_oku_ff  <= 1'b0;
         seen_man_ff  <= 1'b0;
         seen_mul_ff  <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (pop_entry.last) begin
               total_ff    <= '0;
               group_ff    <= '0;
               pending_ff  <= '0;
               seen_oku_ff <= 1'b0;
               seen_man_ff <= 1'b0;
               seen_mul_ff <= '0;
               failed_ff   <= 1'b0;
            end else begin
               total_ff    <= total_in;
               group_ff    <= group_in;
               pending_ff  <= pending_in;
               seen_oku_ff <= seen_oku_in;
               seen_man_ff <= seen_man_in;
               seen_mul_ff <= seen_mul_in;
               failed_ff   <= failed_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && pop_entry.last) begin
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> (rsp_value_ff == '0))
      else $error("error result carries a nonzero value");

   a_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_entry.last) |=> (total_ff == '0 && !failed_ff && !seen_man_ff))
      else $error("parser state not cleared after a result");

endmodule

[hw/rtl/kanji_numeral_parser.sv]
// ----------------------------------------------------------------------------
// kanji_numeral_parser
// Parses a formal Japanese numeral, one code point per word, into an integer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_code_point[20:0], req_last
//   rsp      out        rsp_valid/rsp_ready  rsp_value[29:0], rsp_error
//
// The block takes one word per cycle while the queue is not full. A word is
// classified by the front in the cycle it is accepted and lands in a
// two-entry queue; the back updates the parser state from the queue head.
// The result of a word marked last is visible on rsp in the cycle after it
// leaves the queue, so from req to rsp it passes the queue and the rsp register.
// Reset is synchronous and clears the queue, the parser state and rsp_valid.
// A stalled rsp only holds back a last word at the queue head; other words
// keep flowing, and req_ready drops only when the queue is full.
//
module kanji_numeral_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [20:0] req_code_point,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [29:0] rsp_value,
   output logic        rsp_error
);

   logic               push;
   knp_pkg::entry_type push_entry;
   logic               queue_full;
   logic               pop_valid;
   knp_pkg::entry_type pop_entry;
   logic               pop;

   // The front sorts each code point into digit, multiplier, marker or unknown.
   knp_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_code_point (req_code_point),
      .req_last       (req_last),
      .push           (push),
      .push_entry     (push_entry),
      .queue_full     (queue_full)
   );

   // The queue lets the front keep accepting, until it is full, while the result side stalls.
   knp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   // The back accumulates groups and registers the final result word.
   knp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value),
      .rsp_error (rsp_error)
   );

endmodule
